### rtl/core/twq_pkg.sv
// ----------------------------------------------------------------------------
// twq_pkg
// shared constants, codes and types of the timed wakeup event queue
// ----------------------------------------------------------------------------
package twq_pkg;

    // default sizes
    localparam int unsigned QUEUE_DEPTH_DEF   = 32;
    localparam int unsigned NUM_CONSUMERS_DEF = 16;
    localparam int unsigned TIME_BITS_DEF     = 32;

    // wakeups released by one trigger at most
    localparam int unsigned MAX_RESULTS = 32;

    // fixed field widths
    localparam int unsigned KIND_W = 2;
    localparam int unsigned WHO_W  = 4;
    localparam int unsigned TIN_W  = 32;
    localparam int unsigned ST_W   = 3;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_SCHED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALL   = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_FIRED  = 3'd0;
    localparam logic [ST_W-1:0] ST_SCHED  = 3'd1;
    localparam logic [ST_W-1:0] ST_REDUND = 3'd2;
    localparam logic [ST_W-1:0] ST_PAST   = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd4;
    localparam logic [ST_W-1:0] ST_NONE   = 3'd5;

    // memory port strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // consumer number folded into the consumer range
    function automatic logic [7:0] cons_mod(input logic [WHO_W-1:0] who,
                                            input int unsigned num);
        logic [8:0] v;
        v = {5'd0, who};
        for (int i = 0; i < 8; i++) begin
            if (v >= 9'(num)) begin
                v = v - 9'(num);
            end
        end
        return v[7:0];
    endfunction

endpackage

### rtl/core/twq_qmem.sv
// ----------------------------------------------------------------------------
// twq_qmem
// ring memory of queued wakeups: time and consumer, one write and one read port
// ----------------------------------------------------------------------------
module twq_qmem #(
    parameter int unsigned QUEUE_DEPTH = twq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned TIME_BITS   = twq_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  twq_pkg::t_mem_ctl             i_ctl,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_waddr,
    input  logic [TIME_BITS-1:0]          i_wtime,
    input  logic [twq_pkg::WHO_W-1:0]     i_wwho,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_raddr,
    output logic [TIME_BITS-1:0]          o_rtime,
    output logic [twq_pkg::WHO_W-1:0]     o_rwho
);

    logic [TIME_BITS-1:0]      r_tmem [QUEUE_DEPTH];
    logic [twq_pkg::WHO_W-1:0] r_wmem [QUEUE_DEPTH];
    logic [TIME_BITS-1:0]      r_rtime;
    logic [twq_pkg::WHO_W-1:0] r_rwho;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_tmem[i_waddr] <= i_wtime;
            r_wmem[i_waddr] <= i_wwho;
        end
    end

    // registered read, held between reads
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rtime <= r_tmem[i_raddr];
            r_rwho  <= r_wmem[i_raddr];
        end
    end

    assign o_rtime = r_rtime;
    assign o_rwho  = r_rwho;

endmodule

### rtl/core/twq_lmem.sv
// ----------------------------------------------------------------------------
// twq_lmem
// last scheduled time per consumer, reads as zero until first written
// ----------------------------------------------------------------------------
module twq_lmem #(
    parameter int unsigned NUM_CONSUMERS = twq_pkg::NUM_CONSUMERS_DEF,
    parameter int unsigned TIME_BITS     = twq_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  twq_pkg::t_mem_ctl                i_ctl,
    input  logic [$clog2(NUM_CONSUMERS)-1:0] i_waddr,
    input  logic [TIME_BITS-1:0]             i_wdata,
    input  logic [$clog2(NUM_CONSUMERS)-1:0] i_raddr,
    output logic [TIME_BITS-1:0]             o_rdata
);

    logic [TIME_BITS-1:0]     r_mem [NUM_CONSUMERS];
    logic [NUM_CONSUMERS-1:0] r_vld;
    logic [TIME_BITS-1:0]     r_rdata;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, zero for an entry never written
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/timed_wakeup_event_queue.sv
// ----------------------------------------------------------------------------
// timed_wakeup_event_queue
// time-ordered wakeup queue held in a ring memory, sorted by insertion walk
// ----------------------------------------------------------------------------
//  channel   direction  tdata                          tuser       tlast
//  s         in         consumer_id, time_value        kind        -
//  m         out        woken_consumer, event_time     status      last
//
//  one item at a time; ready is low while an item is being worked on
//  schedule: checked first; if taken into a nonempty queue, later wakeups move up
//  trigger: a queue memory read and a compare per released wakeup; the run stops
//  at a wakeup not yet due; an unknown kind gets only the closing none result
//  output stalls hold the sequencer only when a result waits in the register
//  synchronous active-low reset; no memory clearing pass
// ----------------------------------------------------------------------------
module timed_wakeup_event_queue #(
    parameter int unsigned QUEUE_DEPTH   = twq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned NUM_CONSUMERS = twq_pkg::NUM_CONSUMERS_DEF,
    parameter int unsigned TIME_BITS     = twq_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // consumer_id[3:0], time_value[35:4]
    input  logic [1:0]  i_s_tuser,   // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // woken_consumer[3:0], event_time[35:4]
    output logic [2:0]  o_m_tuser,   // status[2:0]
    output logic        o_m_tlast
);

    localparam int unsigned QAW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CIW = $clog2(NUM_CONSUMERS);
    localparam int unsigned NW  = $clog2(twq_pkg::MAX_RESULTS + 1);
    localparam int unsigned WW  = twq_pkg::WHO_W;
    localparam int unsigned SW  = twq_pkg::ST_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCHK  = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_PUT   = 4'd3;
    localparam logic [3:0] S_SEND  = 4'd4;
    localparam logic [3:0] S_TRD   = 4'd5;
    localparam logic [3:0] S_TCMP  = 4'd6;
    localparam logic [3:0] S_TEND  = 4'd7;

    logic [3:0]           r_state, n_state;
    logic                 r_all, n_all;
    logic [TIME_BITS-1:0] r_time, n_time;
    logic [WW-1:0]        r_who, n_who;
    logic [CIW-1:0]       r_cidx, n_cidx;
    logic [SW-1:0]        r_st, n_st;
    logic [TIME_BITS-1:0] r_cur, n_cur;
    logic [CW-1:0]        r_count, n_count;
    logic [QAW-1:0]       r_head, n_head;
    logic [CW-1:0]        r_j, n_j;
    logic [NW-1:0]        r_n, n_n;
    logic                 r_pv, n_pv;
    logic [WW-1:0]        r_pwho, n_pwho;
    logic [TIME_BITS-1:0] r_ptime, n_ptime;
    logic                 r_ovalid, n_ovalid;
    logic [SW-1:0]        r_ost, n_ost;
    logic [WW-1:0]        r_owho, n_owho;
    logic [TIME_BITS-1:0] r_otime, n_otime;
    logic                 r_olast, n_olast;

    twq_pkg::t_mem_ctl    q_ctl, l_ctl;
    logic [QAW-1:0]       q_waddr, q_raddr;
    logic [TIME_BITS-1:0] q_wtime, q_rtime;
    logic [WW-1:0]        q_wwho, q_rwho;
    logic [CIW-1:0]       l_raddr;
    logic [TIME_BITS-1:0] l_rdata;
    logic                 s_acc, out_free;
    logic [TIME_BITS-1:0] in_time;
    logic [WW-1:0]        in_who;
    logic [TIME_BITS-1:0] cur_after;

    // physical ring slot of a position counted from the head
    function automatic logic [QAW-1:0] slot(input logic [QAW-1:0] head,
                                            input logic [CW-1:0] rel);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(rel);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[QAW-1:0];
    endfunction

    twq_qmem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_qmem (
        .i_clk   (i_clk),
        .i_ctl   (q_ctl),
        .i_waddr (q_waddr),
        .i_wtime (q_wtime),
        .i_wwho  (q_wwho),
        .i_raddr (q_raddr),
        .o_rtime (q_rtime),
        .o_rwho  (q_rwho)
    );

    twq_lmem #(
        .NUM_CONSUMERS (NUM_CONSUMERS),
        .TIME_BITS     (TIME_BITS)
    ) u_lmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (l_ctl),
        .i_waddr (r_cidx),
        .i_wdata (r_time),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    // input unpacking and handshake
    assign in_who     = i_s_tdata[3:0];
    assign in_time    = TIME_BITS'(i_s_tdata[35:4]);
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;
    assign l_raddr    = CIW'(twq_pkg::cons_mod(in_who, NUM_CONSUMERS));
    assign cur_after  = r_all ? r_cur : r_time;

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_all    = r_all;
        n_time   = r_time;
        n_who    = r_who;
        n_cidx   = r_cidx;
        n_st     = r_st;
        n_cur    = r_cur;
        n_count  = r_count;
        n_head   = r_head;
        n_j      = r_j;
        n_n      = r_n;
        n_pv     = r_pv;
        n_pwho   = r_pwho;
        n_ptime  = r_ptime;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ost    = r_ost;
        n_owho   = r_owho;
        n_otime  = r_otime;
        n_olast  = r_olast;
        q_ctl    = '0;
        l_ctl    = '0;
        q_waddr  = slot(r_head, r_j);
        q_raddr  = slot(r_head, r_j - CW'(1));
        q_wtime  = r_time;
        q_wwho   = r_who;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_time = in_time;
                    n_who  = in_who;
                    n_cidx = l_raddr;
                    n_n    = '0;
                    n_pv   = 1'b0;
                    case (i_s_tuser)
                        twq_pkg::KIND_SCHED: begin
                            l_ctl.re = 1'b1;
                            n_state  = S_SCHK;
                        end
                        twq_pkg::KIND_DUE: begin
                            n_all   = 1'b0;
                            n_state = S_TRD;
                        end
                        twq_pkg::KIND_ALL: begin
                            n_all   = 1'b1;
                            n_state = S_TRD;
                        end
                        default: begin
                            n_all   = 1'b1;
                            n_state = S_TEND;
                        end
                    endcase
                end
            end
            S_SCHK: begin
                n_state = S_SEND;
                if (l_rdata == r_time) begin
                    n_st = twq_pkg::ST_REDUND;
                end else if (r_time <= r_cur) begin
                    n_st = twq_pkg::ST_PAST;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_st = twq_pkg::ST_FULL;
                end else begin
                    n_st     = twq_pkg::ST_SCHED;
                    l_ctl.we = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_j      = r_count;
                    if (r_count == '0) begin
                        q_ctl.we = 1'b1;
                        q_waddr  = slot(r_head, '0);
                    end else begin
                        q_ctl.re = 1'b1;
                        q_raddr  = slot(r_head, r_count - CW'(1));
                        n_state  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                // walk back from the tail, moving later wakeups up one slot
                q_ctl.we = 1'b1;
                if (q_rtime > r_time) begin
                    q_wtime = q_rtime;
                    q_wwho  = q_rwho;
                    n_j     = r_j - CW'(1);
                    if (r_j == CW'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        q_ctl.re = 1'b1;
                        q_raddr  = slot(r_head, r_j - CW'(2));
                    end
                end else begin
                    n_state = S_SEND;
                end
            end
            S_PUT: begin
                q_ctl.we = 1'b1;
                n_state  = S_SEND;
            end
            S_SEND: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_st;
                    n_owho   = r_who;
                    n_otime  = r_cur;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_TRD: begin
                if (r_count == '0 || r_n == NW'(twq_pkg::MAX_RESULTS)) begin
                    n_state = S_TEND;
                end else begin
                    q_ctl.re = 1'b1;
                    q_raddr  = r_head;
                    n_state  = S_TCMP;
                end
            end
            S_TCMP: begin
                if (r_all || q_rtime <= r_time) begin
                    if (!r_pv || out_free) begin
                        // previous release goes out, this one becomes pending
                        if (r_pv) begin
                            n_ovalid = 1'b1;
                            n_ost    = twq_pkg::ST_FIRED;
                            n_owho   = r_pwho;
                            n_otime  = r_ptime;
                            n_olast  = 1'b0;
                        end
                        n_pv    = 1'b1;
                        n_pwho  = q_rwho;
                        n_ptime = q_rtime;
                        n_cur   = q_rtime;
                        n_head  = slot(r_head, CW'(1));
                        n_count = r_count - CW'(1);
                        n_n     = r_n + NW'(1);
                        n_state = S_TRD;
                    end
                end else begin
                    n_state = S_TEND;
                end
            end
            S_TEND: begin
                if (out_free) begin
                    n_cur    = cur_after;
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    if (r_pv) begin
                        n_ost   = twq_pkg::ST_FIRED;
                        n_owho  = r_pwho;
                        n_otime = r_ptime;
                    end else begin
                        n_ost   = twq_pkg::ST_NONE;
                        n_owho  = '0;
                        n_otime = cur_after;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= TIME_BITS'(1);
            r_count  <= '0;
            r_head   <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_count  <= n_count;
            r_head   <= n_head;
            r_pv     <= n_pv;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_all   <= n_all;
        r_time  <= n_time;
        r_who   <= n_who;
        r_cidx  <= n_cidx;
        r_st    <= n_st;
        r_j     <= n_j;
        r_n     <= n_n;
        r_pwho  <= n_pwho;
        r_ptime <= n_ptime;
        r_ost   <= n_ost;
        r_owho  <= n_owho;
        r_otime <= n_otime;
        r_olast <= n_olast;
    end

    // output packing
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'd0, 32'(r_otime), r_owho};
    assign o_m_tuser  = r_ost;
    assign o_m_tlast  = r_olast;

endmodule

### rtl/core/twq_checker.sv
// ----------------------------------------------------------------------------
// twq_checker
// port-level checks of the timed wakeup event queue
// ----------------------------------------------------------------------------
module twq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [39:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic        o_m_tlast
);

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // an accepted transaction keeps the input closed next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after a transaction");

    // status within its codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= twq_pkg::ST_NONE)
        else $error("status code out of range");

    // only fired wakeups come in runs
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != twq_pkg::ST_FIRED |-> o_m_tlast)
        else $error("non-fired result without tlast");

endmodule

bind timed_wakeup_event_queue twq_checker u_twq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tlast  (o_m_tlast)
);

### sim/tb_timed_wakeup_event_queue.sv
// ----------------------------------------------------------------------------
// tb_timed_wakeup_event_queue
// self-checking bench: random and directed schedule and trigger transactions,
// results compared against a behavioral queue model kept in a scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_timed_wakeup_event_queue;

    localparam int unsigned DEPTH = twq_pkg::QUEUE_DEPTH_DEF;
    localparam int unsigned NCONS = twq_pkg::NUM_CONSUMERS_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [twq_pkg::ST_W-1:0]  status;
        logic [twq_pkg::WHO_W-1:0] who;
        logic [31:0]               etime;
        logic                      last;
    } t_wake_res;

    // behavioral queue model and expected result store
    class wakeup_scoreboard;
        logic [31:0]               q_time[$];
        logic [twq_pkg::WHO_W-1:0] q_who[$];
        logic [31:0]               now_time;
        logic [31:0]               last_sched[NCONS];
        t_wake_res                 pending[$];

        function void clear_state();
            q_time.delete();
            q_who.delete();
            pending.delete();
            now_time = 32'd1;
            foreach (last_sched[i]) last_sched[i] = '0;
        endfunction

        function void push_res(logic [twq_pkg::ST_W-1:0] st, logic [twq_pkg::WHO_W-1:0] w,
                               logic [31:0] t, logic l);
            t_wake_res r;
            r.status = st;
            r.who = w;
            r.etime = t;
            r.last = l;
            pending.push_back(r);
        endfunction

        // note an accepted input transaction
        function void note_item(logic [1:0] kind, logic [twq_pkg::WHO_W-1:0] w,
                                logic [31:0] t);
            int pos;
            int n;
            logic [twq_pkg::ST_W-1:0] st;
            n = 0;
            if (kind == twq_pkg::KIND_SCHED) begin
                if (last_sched[w] == t) st = twq_pkg::ST_REDUND;
                else if (t <= now_time) st = twq_pkg::ST_PAST;
                else if (q_time.size() >= DEPTH) st = twq_pkg::ST_FULL;
                else begin
                    pos = q_time.size();
                    while (pos > 0 && q_time[pos-1] > t) pos--;
                    q_time.insert(pos, t);
                    q_who.insert(pos, w);
                    last_sched[w] = t;
                    st = twq_pkg::ST_SCHED;
                end
                push_res(st, w, now_time, 1'b1);
            end else if (kind == twq_pkg::KIND_DUE || kind == twq_pkg::KIND_ALL) begin
                while (q_time.size() > 0 && n < twq_pkg::MAX_RESULTS &&
                       (kind == twq_pkg::KIND_ALL || q_time[0] <= t)) begin
                    now_time = q_time[0];
                    push_res(twq_pkg::ST_FIRED, q_who[0], q_time[0], 1'b0);
                    void'(q_time.pop_front());
                    void'(q_who.pop_front());
                    n++;
                end
                if (kind == twq_pkg::KIND_DUE) now_time = t;
                if (n == 0) push_res(twq_pkg::ST_NONE, '0, now_time, 1'b1);
                else pending[pending.size()-1].last = 1'b1;
            end else begin
                push_res(twq_pkg::ST_NONE, '0, now_time, 1'b1);
            end
        endfunction

        // check one accepted result against the oldest expectation
        task check_res(t_wake_res got);
            t_wake_res exp_r;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                report_mismatch("status", got.status, exp_r.status);
            if (got.who !== exp_r.who)
                report_mismatch("woken_consumer", got.who, exp_r.who);
            if (got.etime !== exp_r.etime)
                report_mismatch("event_time", got.etime, exp_r.etime);
            if (got.last !== exp_r.last)
                report_mismatch("last", got.last, exp_r.last);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;   // consumer_id[3:0], time_value[35:4]
    logic [1:0]  i_s_tuser;   // kind[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;   // woken_consumer[3:0], event_time[35:4]
    logic [2:0]  o_m_tuser;   // status[2:0]
    logic        o_m_tlast;

    wakeup_scoreboard sb;
    int  fail_count;
    int  cycle_count;
    bit  quiet_phase;
    bit  hold_sink;

    timed_wakeup_event_queue dut (.*);

    task automatic report_mismatch(string what, longint got, longint exp_v);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp_v, $realtime);
        fail_count++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result sampling at the rising edge
    always @(posedge i_clk) begin
        t_wake_res r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            r.status = o_m_tuser;
            r.who = o_m_tdata[3:0];
            r.etime = o_m_tdata[35:4];
            r.last = o_m_tlast;
            sb.check_res(r);
        end
    end

    // receiver side: random stall bursts and one long hold-off
    initial begin
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_sink) begin
                i_m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_sink = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 18);
                i_m_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // offer one transaction and wait for its acceptance
    task automatic send_item(logic [1:0] kind, logic [3:0] w, logic [31:0] t);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= {4'd0, t, w};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(kind, w, t);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // random transaction mostly near the current time
    task automatic send_random();
        logic [31:0] t;
        int sel;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) t = $urandom;
        else t = sb.now_time + $urandom_range(0, 60) - 5;
        if (sel < 70) send_item(twq_pkg::KIND_SCHED, 4'($urandom_range(0, 15)), t);
        else if (sel < 92) send_item(twq_pkg::KIND_DUE, 4'($urandom), t);
        else if (sel < 98) send_item(twq_pkg::KIND_ALL, 4'($urandom), $urandom);
        else send_item(2'd3, 4'($urandom), $urandom);
    endtask

    initial begin
        sb = new();
        sb.clear_state();
        fail_count = 0;
        cycle_count = 0;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: redundant zero, past, extremes, fill to full, drains
        send_item(twq_pkg::KIND_SCHED, 4'd0, 32'd0);
        send_item(twq_pkg::KIND_SCHED, 4'd1, 32'd1);
        send_item(twq_pkg::KIND_DUE, 4'd0, 32'd0);
        send_item(twq_pkg::KIND_SCHED, 4'd15, 32'hFFFF_FFFF);
        send_item(twq_pkg::KIND_SCHED, 4'd15, 32'hFFFF_FFFF);
        send_item(twq_pkg::KIND_SCHED, 4'd2, 32'd500);
        send_item(twq_pkg::KIND_SCHED, 4'd3, 32'd500);
        send_item(twq_pkg::KIND_SCHED, 4'd4, 32'd200);
        send_item(twq_pkg::KIND_DUE, 4'd0, 32'd500);
        send_item(2'd3, 4'hF, 32'hAAAA_5555);
        send_item(twq_pkg::KIND_ALL, 4'd0, 32'd0);
        send_item(twq_pkg::KIND_ALL, 4'd0, 32'd0);
        send_item(twq_pkg::KIND_DUE, 4'd0, 32'd10);
        // fill past depth with a long receiver hold-off
        hold_sink = 1'b1;
        for (int i = 0; i < 34; i++)
            send_item(twq_pkg::KIND_SCHED, 4'(i), 32'd1000 - 32'(i % 5));
        send_item(twq_pkg::KIND_DUE, 4'd0, 32'h5555_AAAA);
        wait_drained();

        // random part; the final stretch runs without idling
        for (int i = 0; i < 130; i++) begin
            if (i == 105) quiet_phase = 1'b1;
            send_random();
        end
        send_item(twq_pkg::KIND_ALL, 4'd0, 32'd0);
        wait_drained();

        if (fail_count == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### timed_wakeup_event_queue.f
rtl/core/twq_pkg.sv
rtl/core/twq_qmem.sv
rtl/core/twq_lmem.sv
rtl/core/timed_wakeup_event_queue.sv
rtl/core/twq_checker.sv
sim/tb_timed_wakeup_event_queue.sv
